/* design/dtfp_pkg.sv */
// ----------------------------------------------------------------------------
// dtfp_pkg
// Shared types, constants and tables for the decimal text to Q32.32 parser.
// ----------------------------------------------------------------------------
package dtfp_pkg;

    localparam int INT_BITS        = 32;
    localparam int FRAC_BITS       = 32;
    localparam int MAX_FRAC_DIGITS = 9;

    localparam int CH_W        = 8;
    localparam int VALUE_W     = 64;
    localparam int INT_ACC_W   = INT_BITS - 1;
    localparam int FRAC_ACC_W  = 30;             // holds up to nine decimal digits
    localparam int FRAC_CNT_W  = 4;
    localparam int DIV_CNT_W   = $clog2(FRAC_BITS);

    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;

    typedef enum logic [2:0] {
        S_DONE,
        S_LEAD,
        S_INT,
        S_FRAC,
        S_DIV,
        S_HOLD
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SIGN,
        OP_INT,
        OP_FRAC,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_LOAD
    } t_op;

    typedef struct packed {
        logic clear;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic is_digit;
        logic is_space;
        logic is_sign;
        logic is_point;
        logic div_last;
        logic out_free;
    } t_stat;

    // 10^n for n = 0..9
    function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] n);
        logic [FRAC_ACC_W-1:0] r;
        case (n)
            4'd0:    r = 30'd1;
            4'd1:    r = 30'd10;
            4'd2:    r = 30'd100;
            4'd3:    r = 30'd1000;
            4'd4:    r = 30'd10000;
            4'd5:    r = 30'd100000;
            4'd6:    r = 30'd1000000;
            4'd7:    r = 30'd10000000;
            4'd8:    r = 30'd100000000;
            4'd9:    r = 30'd1000000000;
            default: r = 30'd1;
        endcase
        return r;
    endfunction

endpackage

/* design/dtfp_ctrl.sv */
// ----------------------------------------------------------------------------
// dtfp_ctrl
// Parser state machine: character phases, fraction divide and result hand-off.
// ----------------------------------------------------------------------------
module dtfp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_start,
    output logic            o_s_tready,
    input  dtfp_pkg::t_stat i_stat,
    output dtfp_pkg::t_cmd  o_cmd
);
    import dtfp_pkg::*;

    t_state r_state;
    t_state n_state;
    t_state eff_phase;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_DONE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '{clear: 1'b0, op: OP_NONE};
        o_s_tready = (r_state == S_DONE) || (r_state == S_LEAD) ||
                     (r_state == S_INT)  || (r_state == S_FRAC);
        accept     = i_s_tvalid && o_s_tready;
        eff_phase  = i_start ? S_LEAD : r_state;

        if (accept) begin
            o_cmd.clear = i_start;
            case (eff_phase)
                S_LEAD: begin
                    if (i_stat.is_space) begin
                        n_state = S_LEAD;
                    end else if (i_stat.is_sign) begin
                        o_cmd.op = OP_SIGN;
                        n_state  = S_INT;
                    end else if (i_stat.is_digit) begin
                        o_cmd.op = OP_INT;
                        n_state  = S_INT;
                    end else if (i_stat.is_point) begin
                        n_state = S_FRAC;
                    end else begin
                        o_cmd.op = OP_DIV_START;
                        n_state  = S_DIV;
                    end
                end
                S_INT: begin
                    if (i_stat.is_digit) begin
                        o_cmd.op = OP_INT;
                    end else if (i_stat.is_point) begin
                        n_state = S_FRAC;
                    end else begin
                        o_cmd.op = OP_DIV_START;
                        n_state  = S_DIV;
                    end
                end
                S_FRAC: begin
                    if (i_stat.is_digit) begin
                        o_cmd.op = OP_FRAC;
                    end else begin
                        o_cmd.op = OP_DIV_START;
                        n_state  = S_DIV;
                    end
                end
                default: ;
            endcase
        end

        case (r_state)
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_stat.div_last) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DONE;
                end
            end
            default: ;
        endcase
    end

endmodule

/* design/dtfp_dp.sv */
// ----------------------------------------------------------------------------
// dtfp_dp
// Datapath: accumulators, bit-serial fraction divider, output register.
// ----------------------------------------------------------------------------
module dtfp_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dtfp_pkg::t_cmd                 i_cmd,
    output dtfp_pkg::t_stat                o_stat,
    input  logic [dtfp_pkg::CH_W-1:0]      i_ch,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [dtfp_pkg::VALUE_W-1:0]   o_m_tdata,
    output logic                           o_m_tuser
);
    import dtfp_pkg::*;

    localparam int PROD_W = INT_ACC_W + 4;
    localparam logic [INT_ACC_W-1:0] INT_LIM = '1;

    logic                  r_neg, n_neg;
    logic [INT_ACC_W-1:0]  r_int, n_int;
    logic                  r_ovf, n_ovf;
    logic [FRAC_ACC_W-1:0] r_frac, n_frac;       // fraction digits, then remainder
    logic [FRAC_CNT_W-1:0] r_cnt, n_cnt;
    logic [FRAC_BITS-1:0]  r_quot, n_quot;
    logic [DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;
    logic                  r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]    r_value, n_value;
    logic                  r_sat, n_sat;

    logic                  b_neg, b_ovf;
    logic [INT_ACC_W-1:0]  b_int;
    logic [FRAC_ACC_W-1:0] b_frac;
    logic [FRAC_CNT_W-1:0] b_cnt;
    logic [3:0]            dig;
    logic [PROD_W-1:0]     int_ext, int_prod;
    logic [FRAC_ACC_W-1:0] frac_prod, divisor;
    logic [FRAC_ACC_W:0]   rem2;
    logic                  ge;
    logic [VALUE_W-1:0]    mag;

    always_comb begin
        o_stat.is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        o_stat.is_space = (i_ch == CH_SPACE) || ((i_ch >= CH_TAB) && (i_ch <= CH_CR));
        o_stat.is_sign  = (i_ch == CH_PLUS) || (i_ch == CH_MINUS);
        o_stat.is_point = (i_ch == CH_POINT);
        o_stat.div_last = (r_div_cnt == DIV_CNT_W'(FRAC_BITS - 1));
        o_stat.out_free = !r_out_valid || i_m_tready;
    end

    always_comb begin
        b_neg  = i_cmd.clear ? 1'b0 : r_neg;
        b_ovf  = i_cmd.clear ? 1'b0 : r_ovf;
        b_int  = i_cmd.clear ? '0 : r_int;
        b_frac = i_cmd.clear ? '0 : r_frac;
        b_cnt  = i_cmd.clear ? '0 : r_cnt;

        dig      = 4'(i_ch - CH_ZERO);
        int_ext  = PROD_W'(b_int);
        int_prod = (int_ext << 3) + (int_ext << 1) + PROD_W'(dig);
        frac_prod = (b_frac << 3) + (b_frac << 1) + FRAC_ACC_W'(dig);

        // restoring divide step; remainder stays below the divisor
        divisor = pow10(r_cnt);
        rem2    = {r_frac, 1'b0};
        ge      = rem2 >= {1'b0, divisor};

        mag = (VALUE_W'(r_int) << FRAC_BITS) | VALUE_W'(r_quot);

        n_neg       = b_neg;
        n_int       = b_int;
        n_ovf       = b_ovf;
        n_frac      = b_frac;
        n_cnt       = b_cnt;
        n_quot      = r_quot;
        n_div_cnt   = r_div_cnt;
        n_value     = r_value;
        n_sat       = r_sat;
        n_out_valid = r_out_valid && !i_m_tready;

        case (i_cmd.op)
            OP_SIGN: n_neg = (i_ch == CH_MINUS);
            OP_INT: begin
                if (int_prod > PROD_W'(INT_LIM)) begin
                    n_int = INT_LIM;
                    n_ovf = 1'b1;
                end else begin
                    n_int = int_prod[INT_ACC_W-1:0];
                end
            end
            OP_FRAC: begin
                if (b_cnt < FRAC_CNT_W'(MAX_FRAC_DIGITS)) begin
                    n_frac = frac_prod;
                    n_cnt  = b_cnt + 1'b1;
                end
            end
            OP_DIV_START: n_div_cnt = '0;
            OP_DIV_STEP: begin
                n_frac    = ge ? FRAC_ACC_W'(rem2 - {1'b0, divisor}) : FRAC_ACC_W'(rem2);
                n_quot    = {r_quot[FRAC_BITS-2:0], ge};
                n_div_cnt = r_div_cnt + 1'b1;
            end
            OP_LOAD: begin
                n_value     = r_neg ? (~mag + 1'b1) : mag;
                n_sat       = r_ovf;
                n_out_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg       <= 1'b0;
            r_int       <= '0;
            r_ovf       <= 1'b0;
            r_frac      <= '0;
            r_cnt       <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_neg       <= n_neg;
            r_int       <= n_int;
            r_ovf       <= n_ovf;
            r_frac      <= n_frac;
            r_cnt       <= n_cnt;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot  <= n_quot;
        r_value <= n_value;
        r_sat   <= n_sat;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_value;
    assign o_m_tuser  = r_sat;

    // kept fraction digit count never passes the limit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FRAC_CNT_W'(MAX_FRAC_DIGITS))
        else $error("fraction digit count out of range");

    // digits (and later the remainder) stay below 10^count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac < pow10(r_cnt))
        else $error("fraction remainder not below divisor");

    // a result is only loaded when the output register is free
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_LOAD) |-> (!r_out_valid || i_m_tready))
        else $error("result overwrote a pending result");

endmodule

/* design/decimal_text_to_fixed_point.sv */
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point
// Parses ASCII decimal text into a signed Q32.32 fixed-point number.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries one character per request; tuser marks the first
//   character of a new string. Leading blanks (space, codes 9..13) are skipped,
//   then an optional sign, integer digits, an optional point and fraction
//   digits are read. The first character that does not fit ends the string
//   and produces one result; later characters are dropped until the next start.
//   Output stream carries the value in tdata, the integer-clamp flag in tuser.
// Flow:
//   Ordinary characters are taken back to back. The terminating character
//   starts a bit-serial restoring divide of the fraction digits by 10^count,
//   one quotient bit per cycle, then the result is formed and registered once
//   the output register is free. The input stream is held off (tready low)
//   from the terminator until the result is loaded.
// Reset: synchronous, active low; parser waits for a start, output empty.
// Stall: the result sits in an output register; the parser keeps taking
//   characters meanwhile. The next result waits for it to drain, with tready
//   held low while it waits.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input request stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [dtfp_pkg::CH_W-1:0]     i_s_tdata,   // [7:0] ch
    input  logic                          i_s_tuser,   // [0] start_req
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [dtfp_pkg::VALUE_W-1:0]  o_m_tdata,   // [63:0] value (signed Q32.32)
    output logic                          o_m_tuser    // [0] saturated
);
    import dtfp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    dtfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_start    (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dtfp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_ch       (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

/* dv/decimal_text_to_fixed_point_tb.sv */
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_tb
// Self-checking bench for the decimal text to Q32.32 parser. A short table of
// hand-picked strings comes first: blanks, signs, empty strings, a restart
// mid-string and integer clamping. Random well-formed numbers with random
// endings follow, mixed with noise bursts and strings cut off by a new start;
// a behavioral parser predicts their results. Both streams idle at random.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_tb;

    import dtfp_pkg::*;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CH_W-1:0] CH_X     = 8'h78;
    localparam logic [CH_W-1:0] CH_TOP   = 8'hFF;

    localparam logic [63:0] WHOLE_MAX = (64'd1 << (INT_BITS - 1)) - 64'd1;
    localparam int          LIVE_GOAL = 600;
    localparam int          TAIL_CYC  = 40;

    // parser phases of the behavioral model
    typedef enum logic [1:0] {
        P_IDLE,
        P_BLANK,
        P_WHOLE,
        P_FRACT
    } t_parse;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               sat;
    } t_fixed_res;

    // one row of the directed table; want is used only when typed is set
    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            st;
        logic            typed;
        t_fixed_res      want;
    } t_text_row;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [CH_W-1:0]    i_s_tdata  = '0;     // [7:0] ch
    logic               i_s_tuser  = 1'b0;   // [0] start_req
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [VALUE_W-1:0] o_m_tdata;           // [63:0] value (signed Q32.32)
    logic               o_m_tuser;           // [0] saturated

    // behavioral parser state
    t_parse      pst     = P_IDLE;
    logic        neg     = 1'b0;
    logic [63:0] whole   = '0;
    logic        clamped = 1'b0;
    logic [63:0] fract   = '0;
    int unsigned ndig    = 0;

    t_fixed_res  pending_results[$];
    t_text_row   dir_rows[$];
    int          live_items = 0;
    int          fails      = 0;
    int          shown      = 0;
    logic        calm       = 1'b0;   // no idling on either side while set

    decimal_text_to_fixed_point i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // safety net against a hung handshake
    initial begin
        #1600000;
        $display("decimal_text_to_fixed_point regression: fail");
        $finish;
    end

    function automatic void push_whole(input logic [CH_W-1:0] c);
        whole = whole * 64'd10 + 64'(c - CH_ZERO);
        if (whole > WHOLE_MAX) begin
            whole   = WHOLE_MAX;
            clamped = 1'b1;
        end
    endfunction

    // Steps the parser with one character; returns 1 when a number is complete.
    function automatic logic parse_char(input logic [CH_W-1:0] c, input logic st,
                                        output t_fixed_res r);
        logic        digit;
        logic        blank;
        logic        ends;
        logic [63:0] scale;
        logic [63:0] frac_q;
        logic [63:0] mag;
        r     = '0;
        ends  = 1'b0;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        if (st) begin
            // a start drops whatever was in progress
            pst     = P_BLANK;
            neg     = 1'b0;
            whole   = '0;
            clamped = 1'b0;
            fract   = '0;
            ndig    = 0;
        end
        case (pst)
            P_BLANK: begin
                if (!blank) begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        neg = (c == CH_MINUS);
                        pst = P_WHOLE;
                    end else if (digit) begin
                        push_whole(c);
                        pst = P_WHOLE;
                    end else if (c == CH_POINT) begin
                        pst = P_FRACT;
                    end else begin
                        ends = 1'b1;
                    end
                end
            end
            P_WHOLE: begin
                if (digit) push_whole(c);
                else if (c == CH_POINT) pst = P_FRACT;
                else ends = 1'b1;
            end
            P_FRACT: begin
                if (digit) begin
                    // digits past the limit are swallowed
                    if (ndig < MAX_FRAC_DIGITS) begin
                        fract = fract * 64'd10 + 64'(c - CH_ZERO);
                        ndig++;
                    end
                end else begin
                    ends = 1'b1;
                end
            end
            default: ;
        endcase
        if (ends) begin
            scale = 64'd1;
            for (int k = 0; k < ndig; k++) scale = scale * 64'd10;
            frac_q  = (ndig != 0) ? (fract << FRAC_BITS) / scale : 64'd0;
            mag     = (whole << FRAC_BITS) + frac_q;
            r.value = neg ? -mag : mag;
            r.sat   = clamped;
            pst     = P_IDLE;
        end
        return ends;
    endfunction

    // Offers one character, waits for it to be taken, records what it causes.
    task automatic send_char(input logic [CH_W-1:0] c, input logic st,
                             input logic typed, input t_fixed_res want);
        t_fixed_res got;
        while (!calm && $urandom_range(99) < 11) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tuser  <= st;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (st || pst != P_IDLE) live_items++;
        if (parse_char(c, st, got)) pending_results.push_back(typed ? want : got);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_fail(input string what, input t_fixed_res want);
        fails++;
        if (shown < 10) begin
            shown++;
            $display("%s: expected value %h sat %0d, got value %h sat %0d",
                     what, want.value, want.sat, o_m_tdata, o_m_tuser);
        end
    endtask

    // result side: random back-pressure, in-order compare
    always @(posedge i_clk) begin
        t_fixed_res want;
        i_m_tready <= calm || ($urandom_range(99) >= 11);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                note_fail("unexpected result", '0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata !== want.value || o_m_tuser !== want.sat)
                    note_fail("mismatch", want);
            end
        end
    end

    initial begin
        logic [CH_W-1:0] txt[$];
        t_fixed_res      none;
        int              nb;
        int              ni;
        int              nf;
        int              strings;
        none    = '0;
        strings = 0;

        // --- directed table ---
        // ignored: no start since reset
        dir_rows.push_back('{CH_ZERO + 8'd7, 1'b0, 1'b0, none});
        // empty string
        dir_rows.push_back('{CH_NUL, 1'b1, 1'b1, '{64'd0, 1'b0}});
        // sign then blank ends the string, negative zero reads as zero
        dir_rows.push_back('{CH_MINUS, 1'b1, 1'b0, none});
        dir_rows.push_back('{CH_SPACE, 1'b0, 1'b1, '{64'd0, 1'b0}});
        // leading blanks, sign then point, top code ends it: +.5
        dir_rows.push_back('{CH_TAB, 1'b1, 1'b0, none});
        dir_rows.push_back('{CH_CR, 1'b0, 1'b0, none});
        dir_rows.push_back('{CH_PLUS, 1'b0, 1'b0, none});
        dir_rows.push_back('{CH_POINT, 1'b0, 1'b0, none});
        dir_rows.push_back('{CH_ZERO + 8'd5, 1'b0, 1'b0, none});
        dir_rows.push_back('{CH_TOP, 1'b0, 1'b1, '{64'h0000_0000_8000_0000, 1'b0}});
        // "42" cut off by a new start, then a clamped negative integer
        dir_rows.push_back('{CH_ZERO + 8'd4, 1'b1, 1'b0, none});
        dir_rows.push_back('{CH_ZERO + 8'd2, 1'b0, 1'b0, none});
        dir_rows.push_back('{CH_MINUS, 1'b1, 1'b0, none});
        for (int k = 0; k < 10; k++) dir_rows.push_back('{CH_NINE, 1'b0, 1'b0, none});
        dir_rows.push_back('{CH_SLASH, 1'b0, 1'b1, '{64'h8000_0001_0000_0000, 1'b1}});
        // ignored after done
        dir_rows.push_back('{CH_X, 1'b0, 1'b0, none});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_char(dir_rows[k].ch, dir_rows[k].st, dir_rows[k].typed, dir_rows[k].want);

        // sender holds off until the block has delivered everything
        drain_results();

        // --- random part ---
        while (live_items < LIVE_GOAL) begin
            strings++;
            calm = (strings >= 30 && strings < 45);
            txt.delete();
            if ($urandom_range(5) == 0) begin
                // noise burst, sometimes without a start
                nb = $urandom_range(1, 5);
                for (int k = 0; k < nb; k++)
                    send_char(8'($urandom_range(255)), (k == 0) && $urandom_range(1),
                              1'b0, none);
            end else begin
                nb = $urandom_range(0, 2);
                for (int k = 0; k < nb; k++)
                    txt.push_back(($urandom_range(5) == 0) ? CH_SPACE
                                  : CH_TAB + 8'($urandom_range(4)));
                case ($urandom_range(2))
                    0: txt.push_back(CH_PLUS);
                    1: txt.push_back(CH_MINUS);
                    default: ;
                endcase
                ni = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 6);
                for (int k = 0; k < ni; k++) txt.push_back(CH_ZERO + 8'($urandom_range(9)));
                if ($urandom_range(1)) begin
                    txt.push_back(CH_POINT);
                    nf = ($urandom_range(7) == 0) ? $urandom_range(10, 13)
                                                  : $urandom_range(0, 6);
                    for (int k = 0; k < nf; k++)
                        txt.push_back(CH_ZERO + 8'($urandom_range(9)));
                end
                // most strings end; some are left open for the next start to cut
                if ($urandom_range(9) != 0) begin
                    case ($urandom_range(2))
                        0:       txt.push_back(CH_NUL);
                        1:       txt.push_back(CH_SPACE);
                        default: txt.push_back(8'($urandom_range(255)));
                    endcase
                    if ($urandom_range(3) == 0) txt.push_back(8'($urandom_range(255)));
                end
                foreach (txt[k]) send_char(txt[k], k == 0, 1'b0, none);
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (fails == 0)
            $display("decimal_text_to_fixed_point regression: pass");
        else
            $display("decimal_text_to_fixed_point regression: fail");
        $finish;
    end

endmodule
